### sv/prp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page replacement policy - shared package
// Widths, register and policy codes, frame state view and update decision.
// ----------------------------------------------------------------------------
package prp_pkg;

	localparam int NUM_FRAMES     = 8;
	localparam int PAGE_BITS      = 16;
	localparam int SLOT_BITS      = 3;
	localparam int COUNT_BITS     = 4;
	localparam int RANK_BITS      = 3;
	localparam int FAULT_BITS     = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 4;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_POLICY_MODE   = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAMES_IN_USE = 1'b1;

	// policy codes; the unused code behaves as FIFO
	localparam logic [1:0] POLICY_FIFO  = 2'd0;
	localparam logic [1:0] POLICY_LRU   = 2'd1;
	localparam logic [1:0] POLICY_CLOCK = 2'd2;

	typedef logic [PAGE_BITS-1:0]                  page_t;
	typedef logic [SLOT_BITS-1:0]                  slot_t;
	typedef logic [RANK_BITS-1:0]                  rank_t;
	typedef logic [COUNT_BITS-1:0]                 count_t;
	typedef logic [FAULT_BITS-1:0]                 fault_t;
	typedef logic [NUM_FRAMES-1:0]                 frame_mask_t;
	typedef logic [NUM_FRAMES-1:0][PAGE_BITS-1:0]  page_vec_t;
	typedef logic [NUM_FRAMES-1:0][RANK_BITS-1:0]  rank_vec_t;

	// frame state as seen by the decision logic
	typedef struct packed {
		frame_mask_t valid;
		frame_mask_t use_bits;
		page_vec_t   pages;
		rank_vec_t   ranks;
		slot_t       hand;
	} frame_view_t;

	// what one reference does to the frame state
	typedef struct packed {
		logic        hit;
		logic        load;
		logic        evict;
		slot_t       slot;
		page_t       ev_page;
		frame_mask_t age_mask;
		frame_mask_t use_clr;
		logic        hand_wr;
		slot_t       hand_new;
		logic        rank_zero;
	} decision_t;

	// lowest set bit of a frame mask, zero when empty
	function automatic slot_t lowest_set(input frame_mask_t v);
		slot_t r;
		r = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = slot_t'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/prp_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page replacement policy - slot selection
// Hit match, lowest empty frame, rank victim and clock rotating encoder.
// ----------------------------------------------------------------------------
module prp_select (
	input  var prp_pkg::frame_view_t view,
	input  var prp_pkg::page_t       page,
	input  var logic [1:0]           policy,
	input  var prp_pkg::count_t      n,
	output var prp_pkg::decision_t   dec
);
	import prp_pkg::*;

	frame_mask_t managed, match, empty, cand, upper, clr, age;
	slot_t       hand_eff, hit_slot, fill_slot, clk_slot, rank_slot, slot;
	rank_t       best_rank;
	logic        hit, found_empty, evict, aging_on;
	count_t      limit, nm1, slot_inc;

	always_comb begin
		nm1 = n - count_t'(1);
		for (int i = 0; i < NUM_FRAMES; i++) begin
			managed[i] = count_t'(i) < n;
		end
		hand_eff = ({1'b0, view.hand} < n) ? view.hand : '0;

		for (int i = 0; i < NUM_FRAMES; i++) begin
			match[i] = managed[i] & view.valid[i] & (view.pages[i] == page);
			empty[i] = managed[i] & ~view.valid[i];
			cand[i]  = managed[i] & ~view.use_bits[i];
			upper[i] = cand[i] & (slot_t'(i) >= hand_eff);
		end

		hit         = |match;
		hit_slot    = lowest_set(match);
		found_empty = |empty;
		fill_slot   = lowest_set(empty);

		// clock: first clear use bit going round from the hand
		if (|upper) begin
			clk_slot = lowest_set(upper);
		end else if (|cand) begin
			clk_slot = lowest_set(cand);
		end else begin
			clk_slot = hand_eff;
		end
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (cand == '0) begin
				clr[i] = managed[i];
			end else if (clk_slot >= hand_eff) begin
				clr[i] = (slot_t'(i) >= hand_eff) && (slot_t'(i) < clk_slot);
			end else begin
				clr[i] = managed[i] && ((slot_t'(i) >= hand_eff) || (slot_t'(i) < clk_slot));
			end
		end

		// oldest rank, lowest index on a tie
		rank_slot = '0;
		best_rank = view.ranks[0];
		for (int i = 1; i < NUM_FRAMES; i++) begin
			if (managed[i] && (view.ranks[i] > best_rank)) begin
				rank_slot = slot_t'(i);
				best_rank = view.ranks[i];
			end
		end

		evict = !hit && !found_empty;
		if (hit) begin
			slot = hit_slot;
		end else if (found_empty) begin
			slot = fill_slot;
		end else if (policy == POLICY_CLOCK) begin
			slot = clk_slot;
		end else begin
			slot = rank_slot;
		end

		limit    = (!hit && found_empty) ? count_t'(NUM_FRAMES) : {1'b0, view.ranks[slot]};
		aging_on = !hit || (policy == POLICY_LRU);
		for (int i = 0; i < NUM_FRAMES; i++) begin
			age[i] = aging_on && managed[i] && (slot_t'(i) != slot) && view.valid[i]
				&& ({1'b0, view.ranks[i]} < limit) && ({1'b0, view.ranks[i]} < nm1);
		end

		slot_inc = {1'b0, slot} + count_t'(1);

		dec.hit       = hit;
		dec.load      = !hit;
		dec.evict     = evict;
		dec.slot      = slot;
		dec.ev_page   = evict ? view.pages[slot] : '0;
		dec.age_mask  = age;
		dec.use_clr   = (evict && (policy == POLICY_CLOCK)) ? clr : '0;
		dec.hand_wr   = !hit && (found_empty || (policy == POLICY_CLOCK));
		dec.hand_new  = (slot_inc < n) ? slot_inc[SLOT_BITS-1:0] : '0;
		dec.rank_zero = !hit || (policy == POLICY_LRU);
	end

endmodule
`default_nettype wire

### sv/prp_frames.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page replacement policy - frame store
// Frame registers, clock hand and fault counter; applies each decision.
// ----------------------------------------------------------------------------
module prp_frames (
	input  var logic                 clk,
	input  var logic                 arst_n,
	input  var logic                 advance,
	input  var logic                 sos,
	input  var prp_pkg::page_t       page_in,
	input  var prp_pkg::decision_t   dec,
	output var prp_pkg::frame_view_t view,
	output var prp_pkg::fault_t      fault_next
);
	import prp_pkg::*;

	frame_mask_t valid_q, use_q;
	page_vec_t   pages_q;
	rank_vec_t   ranks_q;
	slot_t       hand_q;
	fault_t      fault_q, fault_base;

	// start of sequence: frames seen as cleared for this reference
	always_comb begin
		view.pages = pages_q;
		if (sos) begin
			view.valid    = '0;
			view.use_bits = '0;
			view.ranks    = '0;
			view.hand     = '0;
			fault_base    = '0;
		end else begin
			view.valid    = valid_q;
			view.use_bits = use_q;
			view.ranks    = ranks_q;
			view.hand     = hand_q;
			fault_base    = fault_q;
		end
		if (dec.load && (fault_base != '1)) begin
			fault_next = fault_base + fault_t'(1);
		end else begin
			fault_next = fault_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			use_q   <= '0;
			ranks_q <= '0;
			hand_q  <= '0;
			fault_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				valid_q[i] <= view.valid[i] | (dec.load && (dec.slot == slot_t'(i)));
				use_q[i]   <= (view.use_bits[i] & ~dec.use_clr[i]) | (dec.slot == slot_t'(i));
				if ((dec.slot == slot_t'(i)) && dec.rank_zero) begin
					ranks_q[i] <= '0;
				end else if (dec.age_mask[i]) begin
					ranks_q[i] <= view.ranks[i] + rank_t'(1);
				end else begin
					ranks_q[i] <= view.ranks[i];
				end
			end
			hand_q  <= dec.hand_wr ? dec.hand_new : view.hand;
			fault_q <= fault_next;
		end
	end

	// page numbers: read only behind a valid bit
	always_ff @(posedge clk) begin
		if (advance && dec.load) begin
			pages_q[dec.slot] <= page_in;
		end
	end

endmodule
`default_nettype wire

### sv/page_replacement_policy_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Page replacement policy unit
// Tracks resident pages in a set of frames; FIFO, LRU or clock replacement.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------
//  in        in_valid / in_stall    page_number, start_of_sequence
//  out       out_valid / out_stall  hit, frame_index, evicted_valid,
//                                   evicted_page, fault_total
//  cfg       cfg_write              cfg_index, cfg_data (no read-back)
//
//  One reference per cycle while out_stall is low: a beat is held in the input
//  register, the frame update and the result are settled by one pass of logic
//  and land in the frame registers and the result register at the same edge.
//  Reset clears frames, hand, fault count and selects FIFO with four frames.
//  A stalled result holds the input register; in_stall follows out_stall while both registers hold a beat.
//
module page_replacement_policy_unit (
	input  var logic                                 clk,
	input  var logic                                 arst_n,
	// configuration
	input  var logic                                 cfg_write,
	input  var logic [prp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  var logic [prp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	// reference beats
	input  var logic                                 in_valid,
	output var logic                                 in_stall,
	input  var prp_pkg::page_t                       page_number,
	input  var logic                                 start_of_sequence,
	// result beats
	output var logic                                 out_valid,
	input  var logic                                 out_stall,
	output var logic                                 hit,
	output var prp_pkg::slot_t                       frame_index,
	output var logic                                 evicted_valid,
	output var prp_pkg::page_t                       evicted_page,
	output var prp_pkg::fault_t                      fault_total
);
	import prp_pkg::*;

	// configuration registers
	logic [1:0] policy_q;
	count_t     frames_in_use_q;
	count_t     n_eff;

	// input register
	logic  valid_s1;
	page_t page_s1;
	logic  sos_s1;

	// result register
	logic   out_valid_q;
	logic   hit_q;
	slot_t  frame_index_q;
	logic   evicted_valid_q;
	page_t  evicted_page_q;
	fault_t fault_total_q;

	logic        advance;
	frame_view_t view;
	decision_t   dec;
	fault_t      fault_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q        <= POLICY_FIFO;
			frames_in_use_q <= count_t'(4);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POLICY_MODE:   policy_q        <= cfg_data[1:0];
				REG_FRAMES_IN_USE: frames_in_use_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// zero frames acts as one, too many as all of them
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_eff = count_t'(1);
		end else if (frames_in_use_q > count_t'(NUM_FRAMES)) begin
			n_eff = count_t'(NUM_FRAMES);
		end else begin
			n_eff = frames_in_use_q;
		end
	end

	// the input register moves on whenever the result register can take a beat
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			page_s1 <= page_number;
			sos_s1  <= start_of_sequence;
		end
	end

	prp_select u_select (
		.view   (view),
		.page   (page_s1),
		.policy (policy_q),
		.n      (n_eff),
		.dec    (dec)
	);

	prp_frames u_frames (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.sos        (sos_s1),
		.page_in    (page_s1),
		.dec        (dec),
		.view       (view),
		.fault_next (fault_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q           <= dec.hit;
			frame_index_q   <= dec.slot;
			evicted_valid_q <= dec.evict;
			evicted_page_q  <= dec.ev_page;
			fault_total_q   <= fault_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_total_q;

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page replacement policy unit - self-checking testbench
// Drives page references through the valid/stall input channel, predicts each
// result from a local model of the frames, hand and fault count, and compares
// every result beat field by field. A short scripted run comes first, then
// randomised phases over all policy codes and a range of frame counts.
// ----------------------------------------------------------------------------
module tb_top;
	import prp_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 80;   // long receiver hold-off
	localparam int HOLD_AFTER     = 700;  // result count that triggers it
	// longest quiet stretch of a correct run: hold-off plus a drain plus
	// the longest sender gap stays well under this limit
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 110;
	localparam int MAX_PRINTED    = 100;

	typedef struct packed {
		logic   hit;
		slot_t  frame;
		logic   ev_valid;
		page_t  ev_page;
		fault_t faults;
	} outcome_t;

	// one row of the scripted run: a register write or a reference
	typedef struct packed {
		logic                      is_cfg;
		logic [CFG_INDEX_BITS-1:0] reg_idx;
		logic [CFG_DATA_BITS-1:0]  reg_val;
		page_t                     pg;
		logic                      sos;
		logic                      known;
		outcome_t                  want;
	} script_row_t;

	// ---------------------------------------------------------------- DUT I/O
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	page_t                     page_number = '0;
	logic                      start_of_sequence = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      hit;
	slot_t                     frame_index;
	logic                      evicted_valid;
	page_t                     evicted_page;
	fault_t                    fault_total;

	always #HALF_PERIOD clk = ~clk;

	page_replacement_policy_unit DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.page_number       (page_number),
		.start_of_sequence (start_of_sequence),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.hit               (hit),
		.frame_index       (frame_index),
		.evicted_valid     (evicted_valid),
		.evicted_page      (evicted_page),
		.fault_total       (fault_total)
	);

	// ------------------------------------------------------ frame-state model
	page_t      fr_page [NUM_FRAMES];
	logic       fr_valid[NUM_FRAMES];
	rank_t      fr_rank [NUM_FRAMES];
	logic       fr_use  [NUM_FRAMES];
	int         hand_pos;
	fault_t     fault_count;
	logic [1:0] policy_sel;
	count_t     frames_sel;

	outcome_t    outcomes_due[$];
	script_row_t script[$];
	int          error_count   = 0;
	int          results_seen  = 0;
	int          steady_sender = 0;

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED) begin
			$display("%0t  ERROR  %s", $time, msg);
		end
		error_count++;
	endtask

	function automatic void clear_frames();
		for (int i = 0; i < NUM_FRAMES; i++) begin
			fr_page[i]  = '0;
			fr_valid[i] = 1'b0;
			fr_rank[i]  = '0;
			fr_use[i]   = 1'b0;
		end
		hand_pos    = 0;
		fault_count = '0;
	endfunction

	// register value 0 acts as one frame, anything past the array as all
	function automatic int managed_frames();
		int n;
		n = int'(frames_sel);
		if (n < 1) n = 1;
		if (n > NUM_FRAMES) n = NUM_FRAMES;
		return n;
	endfunction

	// valid managed frames younger than limit move one step older
	function automatic void age_frames(input int n, input int skip, input int limit);
		for (int i = 0; i < n; i++) begin
			if (i != skip && fr_valid[i] && int'(fr_rank[i]) < limit &&
			    int'(fr_rank[i]) < n - 1) begin
				fr_rank[i]++;
			end
		end
	endfunction

	function automatic int next_frame(input int f, input int n);
		return (f + 1 < n) ? f + 1 : 0;
	endfunction

	// applies one reference to the local frame state, returns its result
	function automatic outcome_t resolve_reference(input page_t pg, input logic sos);
		outcome_t o;
		int       n;
		int       slot;
		int       h;
		int       best;
		logic     empty_found;
		o = '0;
		slot = 0;
		empty_found = 1'b0;
		if (sos) clear_frames();
		n = managed_frames();
		h = (hand_pos < n) ? hand_pos : 0;
		for (int i = 0; i < n; i++) begin
			if (!o.hit && fr_valid[i] && fr_page[i] == pg) begin
				o.hit = 1'b1;
				slot = i;
			end
		end
		if (o.hit) begin
			fr_use[slot] = 1'b1;
			if (policy_sel == POLICY_LRU) begin
				age_frames(n, slot, int'(fr_rank[slot]));
				fr_rank[slot] = '0;
			end
		end else begin
			for (int i = 0; i < n; i++) begin
				if (!empty_found && !fr_valid[i]) begin
					empty_found = 1'b1;
					slot = i;
				end
			end
			if (empty_found) begin
				age_frames(n, slot, 256);
				hand_pos = next_frame(slot, n);
			end else if (policy_sel == POLICY_CLOCK) begin
				// second chance: clear use bits until one is found clear
				slot = h;
				for (int s = 0; s <= n; s++) begin
					if (!fr_use[h]) begin
						slot = h;
						break;
					end
					fr_use[h] = 1'b0;
					h = next_frame(h, n);
					slot = h;
				end
				hand_pos = next_frame(slot, n);
				age_frames(n, slot, int'(fr_rank[slot]));
			end else begin
				best = 0;
				for (int i = 0; i < n; i++) begin
					if (fr_rank[i] > fr_rank[best]) best = i;
				end
				slot = best;
				age_frames(n, slot, int'(fr_rank[slot]));
			end
			if (!empty_found) begin
				o.ev_valid = 1'b1;
				o.ev_page  = fr_page[slot];
			end
			fr_page[slot]  = pg;
			fr_valid[slot] = 1'b1;
			fr_rank[slot]  = '0;
			fr_use[slot]   = 1'b1;
			if (fault_count != '1) fault_count++;
		end
		o.frame  = slot_t'(slot);
		o.faults = fault_count;
		return o;
	endfunction

	// ------------------------------------------------------------ sender side
	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// offers one reference beat and records its expected result on acceptance;
	// valid stays high afterwards so back-to-back beats need no second write
	task automatic offer_reference(input page_t pg, input logic sos,
	                               input logic known, input outcome_t want);
		int       gap;
		outcome_t predicted;
		gap = steady_sender ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		page_number       <= pg;
		start_of_sequence <= sos;
		do @(posedge clk); while (in_stall);
		predicted = resolve_reference(pg, sos);
		outcomes_due.push_back(known ? want : predicted);
	endtask

	// drops valid and lets every pending result come out before a write
	task automatic settle();
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
	                              input logic [CFG_DATA_BITS-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_POLICY_MODE) policy_sel = val[1:0];
		else frames_sel = count_t'(val);
		@(posedge clk);
	endtask

	// ---------------------------------------------------------- script rows
	task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
	                       input logic [CFG_DATA_BITS-1:0] val);
		script_row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		script.push_back(r);
	endtask

	task automatic add_ref(input page_t pg, input logic sos);
		script_row_t r;
		r = '0;
		r.pg  = pg;
		r.sos = sos;
		script.push_back(r);
	endtask

	task automatic add_known(input page_t pg, input logic sos, input logic h,
	                         input int fr, input logic ev, input page_t evp,
	                         input int ft);
		script_row_t r;
		r = '0;
		r.pg    = pg;
		r.sos   = sos;
		r.known = 1'b1;
		r.want  = '{h, slot_t'(fr), ev, evp, fault_t'(ft)};
		script.push_back(r);
	endtask

	// ---------------------------------------------------------- receiver side
	int stall_left    = 0;
	int free_left     = 0;
	int pressure_done = 0;

	always @(posedge clk) begin : result_side
		outcome_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (outcomes_due.size() == 0) begin
				report_error($sformatf("result beat %0d with nothing expected",
				                       results_seen));
			end else begin
				want = outcomes_due.pop_front();
				if (hit !== want.hit)
					report_error($sformatf("beat %0d hit %b, expected %b",
					                       results_seen, hit, want.hit));
				if (frame_index !== want.frame)
					report_error($sformatf("beat %0d frame_index %0d, expected %0d",
					                       results_seen, frame_index, want.frame));
				if (evicted_valid !== want.ev_valid)
					report_error($sformatf("beat %0d evicted_valid %b, expected %b",
					                       results_seen, evicted_valid, want.ev_valid));
				if (evicted_page !== want.ev_page)
					report_error($sformatf("beat %0d evicted_page %h, expected %h",
					                       results_seen, evicted_page, want.ev_page));
				if (fault_total !== want.faults)
					report_error($sformatf("beat %0d fault_total %0d, expected %0d",
					                       results_seen, fault_total, want.faults));
			end
		end
		// stall pattern: short stalls between free runs, now and then a long
		// free run; once, a long hold-off so the unit backs up into its input
		if (stall_left == 0 && free_left == 0) begin
			stall_left = pick_gap();
			free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
			                                        : $urandom_range(1, 12);
		end
		if (!pressure_done && results_seen >= HOLD_AFTER) begin
			stall_left    = HOLD_CYCLES;
			pressure_done = 1;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			free_left--;
		end
	end

	// --------------------------------------------------------------- watchdog
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** page_replacement_policy_unit: FAILED **");
			$finish;
		end
	end

	// --------------------------------------------------------------- stimulus
	initial begin : stimulus
		int         n;
		int         r;
		page_t      base;
		page_t      pg;
		logic       sos;
		logic [1:0] pol;
		int         frame_choice[RANDOM_PHASES];

		frame_choice = '{8, 1, 15, 0, 2, 8, 7, 3, 8, 5, 4, 6};
		clear_frames();
		policy_sel = POLICY_FIFO;
		frames_sel = count_t'(4);

		// scripted run; reset gives FIFO over four frames
		add_known(16'h0000, 1'b0, 1'b0, 0, 1'b0, 16'h0000, 1);
		add_known(16'hFFFF, 1'b0, 1'b0, 1, 1'b0, 16'h0000, 2);
		add_known(16'h0000, 1'b0, 1'b1, 0, 1'b0, 16'h0000, 2);
		add_known(16'h0005, 1'b0, 1'b0, 2, 1'b0, 16'h0000, 3);
		add_known(16'h0006, 1'b0, 1'b0, 3, 1'b0, 16'h0000, 4);
		// full: oldest load (page 0 in frame 0) goes
		add_known(16'h0007, 1'b0, 1'b0, 0, 1'b1, 16'h0000, 5);
		add_known(16'hFFFF, 1'b0, 1'b1, 1, 1'b0, 16'h0000, 5);
		// new sequence clears frames and the count
		add_known(16'hAAAA, 1'b1, 1'b0, 0, 1'b0, 16'h0000, 1);
		// LRU: the touched page survives, the least recent one goes
		add_cfg(REG_POLICY_MODE, CFG_DATA_BITS'(POLICY_LRU));
		add_ref(16'h0001, 1'b1);
		add_ref(16'h0002, 1'b0);
		add_ref(16'h0003, 1'b0);
		add_ref(16'h0004, 1'b0);
		add_ref(16'h0001, 1'b0);
		add_ref(16'h0009, 1'b0);
		// clock: all use bits set, so the sweep goes right round
		add_cfg(REG_POLICY_MODE, CFG_DATA_BITS'(POLICY_CLOCK));
		add_ref(16'h0010, 1'b1);
		add_ref(16'h0011, 1'b0);
		add_ref(16'h0012, 1'b0);
		add_ref(16'h0013, 1'b0);
		add_ref(16'h0011, 1'b0);
		add_ref(16'h0014, 1'b0);
		add_ref(16'h0015, 1'b0);
		// zero frames acts as one; hand left outside the managed range
		add_cfg(REG_FRAMES_IN_USE, '0);
		add_ref(16'h0020, 1'b0);
		add_ref(16'h0021, 1'b0);
		// spare policy code acts as FIFO; oversize count clamps to all frames
		add_cfg(REG_POLICY_MODE, CFG_DATA_BITS'(2'd3));
		add_cfg(REG_FRAMES_IN_USE, '1);
		add_ref(16'h8000, 1'b0);
		add_ref(16'h7FFF, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_register(script[i].reg_idx, script[i].reg_val);
			end else begin
				offer_reference(script[i].pg, script[i].sos, script[i].known,
				                script[i].want);
			end
		end

		// random phases; state carries over between settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			pol = 2'(ph % 4);
			write_register(REG_POLICY_MODE, CFG_DATA_BITS'(pol));
			write_register(REG_FRAMES_IN_USE, CFG_DATA_BITS'(frame_choice[ph]));
			steady_sender = (ph % 3 == 2);
			n = managed_frames();
			base = page_t'($urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				sos = (r < 3);
				if (r < 75) begin
					// small working set just over the frame count: hits and evictions
					pg = page_t'(base + $urandom_range(0, n + 2));
				end else if (r < 90) begin
					pg = page_t'($urandom);
				end else begin
					case ($urandom_range(0, 3))
						0: pg = '0;
						1: pg = '1;
						2: pg = page_t'(1) << $urandom_range(0, PAGE_BITS - 1);
						default: pg = ~(page_t'(1) << $urandom_range(0, PAGE_BITS - 1));
					endcase
				end
				offer_reference(pg, sos, 1'b0, '0);
			end
		end

		steady_sender = 0;
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** page_replacement_policy_unit: PASSED **");
		end else begin
			$display("** page_replacement_policy_unit: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
sv/prp_pkg.sv
sv/prp_select.sv
sv/prp_frames.sv
sv/page_replacement_policy_unit.sv
test/tb_top.sv
